// ----- rtl/ffa_pkg.sv -----
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types and constants of the first-fit block allocator: field widths,
// action and status codes, datapath operations and the control/status structs.
// ----------------------------------------------------------------------------
package ffa_pkg;

    // default pool size in bytes
    localparam int unsigned POOL_BYTES_DEF = 16384;

    // field widths of the stream items and the config register
    localparam int unsigned ACT_W  = 2;
    localparam int unsigned REQ_W  = 16;
    localparam int unsigned OFF_W  = 16;
    localparam int unsigned ST_W   = 3;
    localparam int unsigned GR_W   = 14;
    localparam int unsigned FT_W   = 15;
    localparam int unsigned ERR_W  = 16;
    localparam int unsigned CFG_W  = 15;

    // packed stream widths, rounded up to whole bytes
    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 48;

    // byte offset arithmetic: holds a request plus header and a sum of
    // three offsets inside the pool without overflow
    localparam int unsigned ARITH_W = 18;

    // minimum pool size and header size in bytes
    localparam int unsigned MIN_POOL = 8;
    localparam int unsigned HDR_BYTES = 4;
    localparam int unsigned SPLIT_MIN = 8;

    typedef enum logic [ACT_W-1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_QUERY = 2'd2,
        ACT_NOP   = 2'd3
    } t_action;

    typedef enum logic [ST_W-1:0] {
        ST_OK          = 3'd0,
        ST_NO_FIT      = 3'd1,
        ST_BOUNDS      = 3'd2,
        ST_DOUBLE_FREE = 3'd3,
        ST_CORRUPT     = 3'd4
    } t_status;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_START,
        OP_A_STEP,
        OP_A_SPLIT,
        OP_A_TAKE,
        OP_A_TAKE_SPLIT,
        OP_F_CLR,
        OP_F_MERGE,
        OP_W_START,
        OP_W_STEP,
        OP_W_MERGE,
        OP_Q_STEP
    } t_op;

    // controller to datapath
    typedef struct packed {
        t_op     op;
        logic    fin;
        t_status st;
        logic    emit;
        logic    in_ready;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic    clr_last;
        t_action act;
        logic    in_bad;
        logic    fit;
        logic    split;
        logic    split_past;
        logic    a_end;
        logic    sz_zero;
        logic    rd_zero;
        logic    used;
        logic    next_in;
        logic    merge_past;
        logic    p_zero;
        logic    w_hit;
        logic    w_stop;
        logic    w_past;
        logic    w_more;
        logic    q_stop;
        logic    q_more;
        logic    out_free;
    } t_flags;

endpackage

// ----- rtl/ffa_ram.sv -----
// ----------------------------------------------------------------------------
// ffa_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module ffa_ram #(
    parameter int unsigned W     = 16,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/ffa_dp.sv -----
// ----------------------------------------------------------------------------
// ffa_dp
// Allocator datapath: header store, walk pointers, free sum, error counter,
// config register and the output register.
// ----------------------------------------------------------------------------
module ffa_dp #(
    parameter int unsigned POOL_BYTES = ffa_pkg::POOL_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ffa_pkg::t_cmd               i_cmd,
    output ffa_pkg::t_flags             o_flags,
    input  logic                        i_cfg_wen,
    input  logic [ffa_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic [ffa_pkg::ACT_W-1:0]   i_action,
    input  logic [ffa_pkg::REQ_W-1:0]   i_request_bytes,
    input  logic [ffa_pkg::OFF_W-1:0]   i_payload_offset,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [ffa_pkg::ST_W-1:0]    o_status,
    output logic [ffa_pkg::GR_W-1:0]    o_granted_offset,
    output logic [ffa_pkg::FT_W-1:0]    o_free_total,
    output logic [ffa_pkg::ERR_W-1:0]   o_error_total
);

    localparam int unsigned AW    = ffa_pkg::ARITH_W;
    localparam int unsigned PW    = $clog2(POOL_BYTES + 1);
    localparam int unsigned HW    = PW + 1;
    localparam int unsigned DEPTH = (POOL_BYTES + 3) / 4;
    localparam int unsigned IW    = $clog2(DEPTH);

    // registers
    logic [PW-1:0]              r_pool;
    logic [IW-1:0]              r_clr_idx;
    logic [AW-1:0]              r_nsize;
    logic [AW-1:0]              r_p;
    logic [AW-1:0]              r_psz;
    logic [AW-1:0]              r_q;
    logic [AW-1:0]              r_sum;
    logic [AW-1:0]              r_gr;
    ffa_pkg::t_status           r_st;
    logic [ffa_pkg::ERR_W-1:0]  r_err;
    logic                       r_o_valid;
    ffa_pkg::t_status           r_o_status;
    logic [ffa_pkg::GR_W-1:0]   r_o_gr;
    logic [ffa_pkg::FT_W-1:0]   r_o_ft;
    logic [ffa_pkg::ERR_W-1:0]  r_o_err;

    // combinational
    logic [HW-1:0]              rd;
    logic [AW-1:0]              sz;
    logic                       used;
    logic [AW-1:0]              pool_w;
    logic [AW-1:0]              p_sz;
    logic [AW-1:0]              q_sz;
    logic [AW-1:0]              off_w;
    logic [AW-1:0]              nbytes;
    ffa_pkg::t_action           in_act;
    logic                       next_in;
    logic                       we;
    logic                       re;
    logic [AW-1:0]              waddr_w;
    logic [AW-1:0]              raddr_w;
    logic [IW-1:0]              widx;
    logic [HW-1:0]              wdata;
    logic [ffa_pkg::CFG_W+1:0]  cfg_v;
    logic [PW-1:0]              n_pool;
    logic                       is_err;

    ffa_ram #(
        .W     (HW),
        .DEPTH (DEPTH)
    ) u_hdr (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (widx),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr_w[IW+1:2]),
        .o_rdata (rd)
    );

    // header fields and offsets
    assign sz      = AW'(rd[PW-1:0]);
    assign used    = rd[PW];
    assign pool_w  = AW'(r_pool);
    assign p_sz    = r_p + sz;
    assign q_sz    = r_q + sz;
    assign off_w   = AW'(i_payload_offset);
    assign nbytes  = (AW'(i_request_bytes) + AW'(3)) & ~AW'(3);
    assign in_act  = ffa_pkg::t_action'(i_action);
    assign next_in = p_sz < pool_w;

    // status flags for the controller
    always_comb begin
        o_flags.clr_last   = r_clr_idx == IW'(DEPTH - 1);
        o_flags.act        = in_act;
        o_flags.in_bad     = (off_w >= pool_w) || (off_w < AW'(ffa_pkg::HDR_BYTES))
                             || (i_payload_offset[1:0] != 2'b00);
        o_flags.fit        = !used && (sz >= r_nsize);
        o_flags.split      = sz >= (r_nsize + AW'(ffa_pkg::SPLIT_MIN));
        o_flags.split_past = (r_p + r_nsize) >= pool_w;
        o_flags.a_end      = p_sz >= pool_w;
        o_flags.sz_zero    = sz == '0;
        o_flags.rd_zero    = rd == '0;
        o_flags.used       = used;
        o_flags.next_in    = next_in;
        o_flags.merge_past = (p_sz + r_psz) > pool_w;
        o_flags.p_zero     = r_p == '0;
        o_flags.w_hit      = q_sz == r_p;
        o_flags.w_stop     = (sz == '0) || (q_sz >= pool_w);
        o_flags.w_past     = (q_sz + r_psz) > pool_w;
        o_flags.w_more     = q_sz < r_p;
        o_flags.q_stop     = (sz == '0) || (sz > (pool_w - r_p))
                             || (sz < AW'(ffa_pkg::HDR_BYTES));
        o_flags.q_more     = p_sz < pool_w;
        o_flags.out_free   = !r_o_valid || i_out_ready;
    end

    // header store ports per operation
    always_comb begin
        we      = 1'b0;
        re      = 1'b0;
        waddr_w = r_p;
        raddr_w = '0;
        wdata   = '0;
        case (i_cmd.op)
            ffa_pkg::OP_CLEAR: begin
                we    = 1'b1;
                wdata = (r_clr_idx == '0) ? {1'b0, r_pool} : '0;
            end
            ffa_pkg::OP_START: begin
                re      = 1'b1;
                raddr_w = (in_act == ffa_pkg::ACT_FREE)
                          ? off_w - AW'(ffa_pkg::HDR_BYTES) : '0;
            end
            ffa_pkg::OP_A_STEP: begin
                re      = 1'b1;
                raddr_w = p_sz;
            end
            ffa_pkg::OP_A_SPLIT: begin
                we      = 1'b1;
                waddr_w = r_p + r_nsize;
                wdata   = {1'b0, sz[PW-1:0] - r_nsize[PW-1:0]};
            end
            ffa_pkg::OP_A_TAKE: begin
                we    = 1'b1;
                wdata = {1'b1, sz[PW-1:0]};
            end
            ffa_pkg::OP_A_TAKE_SPLIT: begin
                we    = 1'b1;
                wdata = {1'b1, r_nsize[PW-1:0]};
            end
            ffa_pkg::OP_F_CLR: begin
                we      = 1'b1;
                wdata   = {1'b0, sz[PW-1:0]};
                re      = 1'b1;
                raddr_w = next_in ? p_sz : '0;
            end
            ffa_pkg::OP_F_MERGE: begin
                we    = 1'b1;
                wdata = {1'b0, r_psz[PW-1:0] + sz[PW-1:0]};
                re    = 1'b1;
            end
            ffa_pkg::OP_W_START: begin
                re = 1'b1;
            end
            ffa_pkg::OP_W_STEP: begin
                re      = 1'b1;
                raddr_w = q_sz;
            end
            ffa_pkg::OP_W_MERGE: begin
                we      = 1'b1;
                waddr_w = r_q;
                wdata   = {1'b0, r_psz[PW-1:0] + sz[PW-1:0]};
            end
            ffa_pkg::OP_Q_STEP: begin
                re      = 1'b1;
                raddr_w = p_sz;
            end
            default: begin
                we = 1'b0;
            end
        endcase
        widx = (i_cmd.op == ffa_pkg::OP_CLEAR) ? r_clr_idx : waddr_w[IW+1:2];
    end

    // pool size clamp on config write
    always_comb begin
        cfg_v = (ffa_pkg::CFG_W + 2)'(i_cfg_wdata);
        if (cfg_v < (ffa_pkg::CFG_W + 2)'(ffa_pkg::MIN_POOL)) begin
            cfg_v = (ffa_pkg::CFG_W + 2)'(ffa_pkg::MIN_POOL);
        end else if (cfg_v > (ffa_pkg::CFG_W + 2)'(POOL_BYTES)) begin
            cfg_v = (ffa_pkg::CFG_W + 2)'(POOL_BYTES);
        end
        n_pool = PW'(cfg_v);
    end

    assign is_err = (i_cmd.st == ffa_pkg::ST_BOUNDS) || (i_cmd.st == ffa_pkg::ST_DOUBLE_FREE)
                    || (i_cmd.st == ffa_pkg::ST_CORRUPT);

    // control registers: pool size, clear sweep, error count, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool    <= PW'(POOL_BYTES);
            r_clr_idx <= '0;
            r_err     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                r_pool    <= n_pool;
                r_clr_idx <= '0;
            end else if (i_cmd.op == ffa_pkg::OP_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (i_cmd.fin && is_err && (r_err != '1)) begin
                r_err <= r_err + 1'b1;
            end
            if (i_cmd.emit) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // walk registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            ffa_pkg::OP_START: begin
                r_nsize <= nbytes + AW'(ffa_pkg::HDR_BYTES);
                r_p     <= (in_act == ffa_pkg::ACT_FREE)
                           ? off_w - AW'(ffa_pkg::HDR_BYTES) : '0;
                r_sum   <= '0;
                r_gr    <= '0;
            end
            ffa_pkg::OP_A_STEP: begin
                r_p <= p_sz;
            end
            ffa_pkg::OP_A_SPLIT, ffa_pkg::OP_A_TAKE: begin
                r_gr <= r_p + AW'(ffa_pkg::HDR_BYTES);
            end
            ffa_pkg::OP_F_CLR: begin
                r_psz <= sz;
                r_q   <= '0;
            end
            ffa_pkg::OP_F_MERGE: begin
                r_psz <= r_psz + sz;
            end
            ffa_pkg::OP_W_START: begin
                r_q <= '0;
            end
            ffa_pkg::OP_W_STEP: begin
                r_q <= q_sz;
            end
            ffa_pkg::OP_Q_STEP: begin
                r_p <= p_sz;
                if (!used) begin
                    r_sum <= r_sum + sz;
                end
            end
            default: begin
                r_p <= r_p;
            end
        endcase
    end

    // status capture on finish, output register on emit
    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_st <= i_cmd.st;
        end
        if (i_cmd.emit) begin
            r_o_status <= r_st;
            r_o_gr     <= r_gr[ffa_pkg::GR_W-1:0];
            r_o_ft     <= r_sum[ffa_pkg::FT_W-1:0];
            r_o_err    <= r_err;
        end
    end

    assign o_out_valid      = r_o_valid;
    assign o_status         = r_o_status;
    assign o_granted_offset = r_o_gr;
    assign o_free_total     = r_o_ft;
    assign o_error_total    = r_o_err;

endmodule

// ----- rtl/ffa_ctrl.sv -----
// ----------------------------------------------------------------------------
// ffa_ctrl
// Allocator controller: sequences the clear sweep, the allocate, free and
// query walks, and the hand-off of each result to the output register.
// ----------------------------------------------------------------------------
module ffa_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_cfg_wen,
    input  ffa_pkg::t_flags i_flags,
    output ffa_pkg::t_cmd   o_cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_A_CHK,
        S_A_NXT,
        S_A_FIN,
        S_F_CHK,
        S_F_NCHK,
        S_W_CHK,
        S_Q_CHK,
        S_OUT
    } t_state;

    t_state        r_state;
    t_state        n_state;
    ffa_pkg::t_cmd cmd;

    // next state and datapath command
    always_comb begin
        n_state = r_state;
        cmd     = '{op: ffa_pkg::OP_NONE, fin: 1'b0, st: ffa_pkg::ST_OK,
                    emit: 1'b0, in_ready: 1'b0};
        case (r_state)
            S_CLEAR: begin
                cmd.op = ffa_pkg::OP_CLEAR;
                if (i_flags.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                cmd.in_ready = 1'b1;
                if (i_in_valid) begin
                    cmd.op = ffa_pkg::OP_START;
                    case (i_flags.act)
                        ffa_pkg::ACT_ALLOC: n_state = S_A_CHK;
                        ffa_pkg::ACT_FREE: begin
                            if (i_flags.in_bad) begin
                                cmd.fin = 1'b1;
                                cmd.st  = ffa_pkg::ST_BOUNDS;
                                n_state = S_OUT;
                            end else begin
                                n_state = S_F_CHK;
                            end
                        end
                        ffa_pkg::ACT_QUERY: n_state = S_Q_CHK;
                        default: begin
                            cmd.fin = 1'b1;
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            // first-fit walk, one header per cycle
            S_A_CHK, S_A_NXT: begin
                if ((r_state == S_A_NXT) && i_flags.rd_zero) begin
                    cmd.fin = 1'b1;
                    cmd.st  = ffa_pkg::ST_CORRUPT;
                    n_state = S_OUT;
                end else if (i_flags.fit) begin
                    if (i_flags.split) begin
                        if (i_flags.split_past) begin
                            cmd.fin = 1'b1;
                            cmd.st  = ffa_pkg::ST_CORRUPT;
                            n_state = S_OUT;
                        end else begin
                            cmd.op  = ffa_pkg::OP_A_SPLIT;
                            n_state = S_A_FIN;
                        end
                    end else begin
                        cmd.op  = ffa_pkg::OP_A_TAKE;
                        cmd.fin = 1'b1;
                        n_state = S_OUT;
                    end
                end else if (i_flags.a_end) begin
                    cmd.fin = 1'b1;
                    cmd.st  = ffa_pkg::ST_NO_FIT;
                    n_state = S_OUT;
                end else if (i_flags.sz_zero) begin
                    cmd.fin = 1'b1;
                    cmd.st  = ffa_pkg::ST_CORRUPT;
                    n_state = S_OUT;
                end else begin
                    cmd.op  = ffa_pkg::OP_A_STEP;
                    n_state = S_A_NXT;
                end
            end
            S_A_FIN: begin
                cmd.op  = ffa_pkg::OP_A_TAKE_SPLIT;
                cmd.fin = 1'b1;
                n_state = S_OUT;
            end
            // free: clear used flag, then look at the next block
            S_F_CHK: begin
                if (!i_flags.used) begin
                    cmd.fin = 1'b1;
                    cmd.st  = ffa_pkg::ST_DOUBLE_FREE;
                    n_state = S_OUT;
                end else begin
                    cmd.op = ffa_pkg::OP_F_CLR;
                    if (i_flags.next_in) begin
                        n_state = S_F_NCHK;
                    end else if (i_flags.p_zero) begin
                        cmd.fin = 1'b1;
                        n_state = S_OUT;
                    end else begin
                        n_state = S_W_CHK;
                    end
                end
            end
            S_F_NCHK: begin
                if (!i_flags.used && i_flags.merge_past) begin
                    cmd.fin = 1'b1;
                    cmd.st  = ffa_pkg::ST_CORRUPT;
                    n_state = S_OUT;
                end else begin
                    cmd.op = i_flags.used ? ffa_pkg::OP_W_START : ffa_pkg::OP_F_MERGE;
                    if (i_flags.p_zero) begin
                        cmd.fin = 1'b1;
                        n_state = S_OUT;
                    end else begin
                        n_state = S_W_CHK;
                    end
                end
            end
            // search for the previous block from offset 0
            S_W_CHK: begin
                if (i_flags.w_hit) begin
                    cmd.fin = 1'b1;
                    n_state = S_OUT;
                    if (!i_flags.used) begin
                        if (i_flags.w_past) begin
                            cmd.st = ffa_pkg::ST_CORRUPT;
                        end else begin
                            cmd.op = ffa_pkg::OP_W_MERGE;
                        end
                    end
                end else if (i_flags.w_stop) begin
                    cmd.fin = 1'b1;
                    n_state = S_OUT;
                end else begin
                    cmd.op = ffa_pkg::OP_W_STEP;
                    if (!i_flags.w_more) begin
                        cmd.fin = 1'b1;
                        n_state = S_OUT;
                    end
                end
            end
            // free byte sum over the chain
            S_Q_CHK: begin
                if (i_flags.q_stop) begin
                    cmd.fin = 1'b1;
                    n_state = S_OUT;
                end else begin
                    cmd.op = ffa_pkg::OP_Q_STEP;
                    if (!i_flags.q_more) begin
                        cmd.fin = 1'b1;
                        n_state = S_OUT;
                    end
                end
            end
            S_OUT: begin
                if (i_flags.out_free) begin
                    cmd.emit = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
        // a new pool size restarts the clear sweep
        if (i_cfg_wen) begin
            n_state = S_CLEAR;
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd = cmd;

endmodule

// ----- rtl/first_fit_block_allocator_top.sv -----
// ----------------------------------------------------------------------------
// first_fit_block_allocator_top
// First-fit allocator with block splitting and free-block coalescing.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream takes one request per transfer: allocate, free, query or no-op.
//   Master stream returns one result per request: status, granted payload
//   offset, free byte total and the saturating error count.
//   Config port writes the pool size; the pool becomes one free block.
// Timing:
//   The header store has one read port with a registered read, so the walk
//   visits one block header per cycle. Allocate walks the blocks passed
//   before the fit, with one more step on a split, query walks the chain,
//   and free walks the blocks in front of the freed one.
// Reset and config:
//   After reset and after each config write the header store is cleared, one
//   word per cycle, over all (POOL_BYTES + 3) / 4 words (4096 by default); no
//   request is taken during the sweep.
// Stall:
//   The result sits in an output register; a request is taken while it
//   waits, and the next result waits until the register is free.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_top #(
    parameter int unsigned POOL_BYTES = ffa_pkg::POOL_BYTES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wen,
    input  logic [ffa_pkg::CFG_W-1:0]          i_cfg_wdata,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // action[1:0], request_bytes[17:2], payload_offset[33:18], zero pad
    input  logic [ffa_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // status[2:0], granted_offset[16:3], free_total[31:17], error_total[47:32]
    output logic [ffa_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata
);

    ffa_pkg::t_cmd             cmd;
    ffa_pkg::t_flags           flags;
    logic [ffa_pkg::ST_W-1:0]  status;
    logic [ffa_pkg::GR_W-1:0]  granted_offset;
    logic [ffa_pkg::FT_W-1:0]  free_total;
    logic [ffa_pkg::ERR_W-1:0] error_total;

    ffa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_cfg_wen  (i_cfg_wen),
        .i_flags    (flags),
        .o_cmd      (cmd)
    );

    ffa_dp #(
        .POOL_BYTES (POOL_BYTES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_flags          (flags),
        .i_cfg_wen        (i_cfg_wen),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_action         (i_s_axis_tdata[1:0]),
        .i_request_bytes  (i_s_axis_tdata[17:2]),
        .i_payload_offset (i_s_axis_tdata[33:18]),
        .i_out_ready      (i_m_axis_tready),
        .o_out_valid      (o_m_axis_tvalid),
        .o_status         (status),
        .o_granted_offset (granted_offset),
        .o_free_total     (free_total),
        .o_error_total    (error_total)
    );

    assign o_s_axis_tready = cmd.in_ready;
    assign o_m_axis_tdata  = {error_total, free_total, granted_offset, status};

`ifndef SYNTHESIS
    // a pool size write always starts a clear sweep
    a_cfg_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wen |=> !o_s_axis_tready)
        else $error("request accepted right after pool size write");

    // a granted offset only comes with a successful status
    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tdata[16:3] != '0))
            |-> (o_m_axis_tdata[2:0] == ffa_pkg::ST_OK))
        else $error("granted offset with failing status");

    // a free total only comes with a successful status
    a_total_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tdata[31:17] != '0))
            |-> (o_m_axis_tdata[2:0] == ffa_pkg::ST_OK))
        else $error("free total with failing status");

    // error count never goes down between shown results
    a_err_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |=> (!o_m_axis_tvalid
            || (o_m_axis_tdata[47:32] >= $past(o_m_axis_tdata[47:32]))))
        else $error("error count decreased");
`endif

endmodule
